FILE: rtl/srs_pkg.sv
// Shared types, constants and helpers of the selective-repeat sender.
package srs_pkg;

	localparam int MAX_PACKETS_HELD_DEF = 16;
	localparam int WINDOW_LIMIT_DEF     = 8;

	localparam int IDX_W      = 5;   // carrier width of a packet index
	localparam int SEQ_W      = 5;
	localparam int Q_W        = 12;  // Q4.8 window values
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PACKET_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMEOUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_THRESHOLD = 3'd5;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [1:0] KIND_SEND    = 2'd0;
	localparam logic [1:0] KIND_TIMEOUT = 2'd1;
	localparam logic [1:0] KIND_FAST    = 2'd2;
	localparam logic [1:0] KIND_STATUS  = 2'd3;

	localparam logic [1:0] STAT_RUNNING = 2'd0;
	localparam logic [1:0] STAT_DONE    = 2'd1;
	localparam logic [1:0] STAT_FAILED  = 2'd2;

	localparam logic [7:0] ACK_FLAG_MASK = 8'h02;
	localparam logic [Q_W-1:0] ONE_Q = 12'd256;

	typedef enum logic [1:0] {OP_START, OP_ACK, OP_TICK, OP_NOP} srs_op_t;

	typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_DONE, PH_FAIL} srs_phase_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ACK_EVAL, ST_RTT_UPD, ST_RTT_TMO, ST_ACK_WIN, ST_DIV, ST_DIV_END,
		ST_FR_EMIT, ST_BASE, ST_TICK_RD, ST_TICK_EVAL, ST_TICK_EMIT, ST_POST,
		ST_FILL, ST_FILL_EMIT, ST_STATUS
	} srs_state_t;

	typedef struct packed {
		srs_op_t          op;
		logic [IDX_W-1:0] idx;
		logic [31:0]      now;
	} srs_entry_t;

	// clamp a Q4.8 value into [one packet, m]
	function automatic logic [Q_W-1:0] clamp_q(input logic [Q_W:0] v, input logic [Q_W-1:0] m);
		logic [Q_W-1:0] r;
		if (v < {1'b0, ONE_Q})
			r = ONE_Q;
		else if (v > {1'b0, m})
			r = m;
		else
			r = v[Q_W-1:0];
		return r;
	endfunction

	function automatic logic [1:0] status_of(input srs_phase_t ph);
		logic [1:0] r;
		unique case (ph)
			PH_DONE: r = STAT_DONE;
			PH_FAIL: r = STAT_FAILED;
			default: r = STAT_RUNNING;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/srs_chan_if.sv
// Request and result channel interfaces of the selective-repeat sender.
interface srs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  ack_flags;
	logic [7:0]  ack_number;
	logic [31:0] time_now_ms;
	modport source(output valid, command, ack_flags, ack_number, time_now_ms, input ready);
	modport sink(input valid, command, ack_flags, ack_number, time_now_ms, output ready);
endinterface

interface srs_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [4:0]  sequence_res;
	logic [1:0]  transfer_status;
	logic [11:0] window_q;
	logic [11:0] threshold_q;
	logic [15:0] timeout_ms;
	logic        last;
	modport source(output valid, kind, sequence_res, transfer_status, window_q, threshold_q,
		timeout_ms, last, input ready);
	modport sink(input valid, kind, sequence_res, transfer_status, window_q, threshold_q,
		timeout_ms, last, output ready);
endinterface

FILE: rtl/srs_front.sv
// Request intake: decodes each event and queues it for the sequencer.
module srs_front #(
	parameter int MAX_PACKETS_HELD = srs_pkg::MAX_PACKETS_HELD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	srs_req_if.sink            req,
	output srs_pkg::srs_entry_t entry,
	output logic               entry_valid,
	input  logic               entry_ready
);
	import srs_pkg::*;

	localparam int CAP = (MAX_PACKETS_HELD < 31) ? MAX_PACKETS_HELD : 31;
	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int NW  = $clog2(QUEUE_DEPTH + 1);

	srs_entry_t          buf_q [QUEUE_DEPTH];
	logic [PW-1:0]       wr_q, rd_q;
	logic [NW-1:0]       cnt_q;
	srs_entry_t          dec;
	logic [7:0]          num_m1;
	logic                push, pop;

	// classify; acks without the ack flag or that can never match a packet become no-ops
	always_comb begin
		num_m1  = req.ack_number - 8'd1;
		dec.now = req.time_now_ms;
		dec.idx = num_m1[IDX_W-1:0];
		unique case (req.command)
			CMD_START: dec.op = OP_START;
			CMD_ACK: begin
				if ((req.ack_flags & ACK_FLAG_MASK) != 8'd0 && req.ack_number != 8'd0
						&& 32'(req.ack_number) <= CAP)
					dec.op = OP_ACK;
				else
					dec.op = OP_NOP;
			end
			CMD_TICK: dec.op = OP_TICK;
			default:  dec.op = OP_NOP;
		endcase
	end

	assign req.ready   = cnt_q < NW'(QUEUE_DEPTH);
	assign push        = req.valid && req.ready;
	assign entry_valid = cnt_q != '0;
	assign pop         = entry_valid && entry_ready;
	assign entry       = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + NW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= dec;
	end

endmodule

FILE: rtl/srs_back.sv
// Event sequencer: per-packet state, window control, RTT estimator, results.
module srs_back #(
	parameter int MAX_PACKETS_HELD = srs_pkg::MAX_PACKETS_HELD_DEF,
	parameter int WINDOW_LIMIT     = srs_pkg::WINDOW_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srs_pkg::srs_entry_t             entry,
	input  logic                            entry_valid,
	output logic                            entry_ready,
	input  logic                            write_enable,
	input  logic [srs_pkg::CFG_IDX_W-1:0]   write_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0]  write_data,
	srs_res_if.source                       res
);
	import srs_pkg::*;

	localparam int CAP = (MAX_PACKETS_HELD < 31) ? MAX_PACKETS_HELD : 31;
	localparam int IW  = $clog2(CAP);
	localparam int CW  = $clog2(CAP + 1);
	localparam int EW  = ((CW > 5) ? CW : 5) + 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAP);
	localparam int CMAX_I = (WINDOW_LIMIT * 256 > 4095) ? 4095 : WINDOW_LIMIT * 256;
	localparam logic [Q_W-1:0] CWND_MAX = CMAX_I[Q_W-1:0];
	localparam int SSTH_RST_I = (2048 > CMAX_I) ? CMAX_I : 2048;
	localparam logic [Q_W-1:0] SSTH_RST = SSTH_RST_I[Q_W-1:0];
	localparam logic [4:0] WL_C = 5'(WINDOW_LIMIT);
	localparam logic [4:0] DIV_LAST = 5'd16;

	// configuration
	logic [4:0]  pkt_cnt_q;
	logic [15:0] init_tmo_q, min_tmo_q, max_tmo_q;
	logic [3:0]  retry_lim_q, init_thr_q;

	// control
	srs_state_t  state_q, state_d;
	srs_phase_t  phase_q;
	logic [CW-1:0] total_q, base_q, next_q, i_q, rp_q;
	logic [CAP-1:0] acked_q, sent_q, samp_q;
	logic [3:0]  retry_q [CAP];
	logic [2:0]  dup_q [CAP];
	logic [Q_W-1:0] cwnd_q, ssth_q;
	logic [23:0] srtt_q, rttvar_q;
	logic [15:0] tmo_q;
	logic        rtt_valid_q, fr_q;
	logic [4:0]  div_cnt_q;
	logic        res_valid_q;

	// payload
	logic [IW-1:0] idx_q;
	logic [31:0] now_q;
	logic [31:0] send_mem [CAP];
	logic [31:0] rd_data_q;
	logic [23:0] sample_q;
	logic [11:0] rem_q;
	logic [8:0]  quo_q;
	logic [1:0]  kind_q, stat_q;
	logic [SEQ_W-1:0] seq_q;
	logic [Q_W-1:0] win_out_q, thr_out_q;
	logic [15:0] tmo_out_q;
	logic        last_q;

	// decisions
	logic [CW-1:0] idx_cw, tgt_cw;
	logic [IW-1:0] i_ix, tgt_ix;
	logic [31:0] elapsed;
	logic        tick_due, tick_fail, tick_retx;
	logic        ack_new, dup3, tgt_ok, fr_fail, fr_retx;
	logic [2:0]  dup_inc;
	logic [3:0]  fl_raw;
	logic [4:0]  flight;
	logic [EW-1:0] win_end;
	logic        fill_go, base_adv, out_free;
	logic [Q_W-1:0] ss_half, fr_cwnd;
	logic [20:0] el_sat;
	logic [23:0] s_new, err;
	logic [25:0] rv_sum;
	logic [26:0] sr_sum, tq_sum;
	logic [23:0] tq;
	logic [15:0] tmo_new;
	logic [12:0] trial;
	logic        ge;
	logic [CW-1:0] total_new;

	// outputs of the sequencer
	logic        out_load;
	logic [1:0]  out_kind;
	logic [SEQ_W-1:0] out_seq;
	logic        out_last;
	logic        mem_we;
	logic [IW-1:0] mem_wa, rd_addr;

	always_comb begin
		idx_cw  = CW'(idx_q);
		tgt_cw  = idx_cw + CW'(1);
		i_ix    = i_q[IW-1:0];
		tgt_ix  = tgt_cw[IW-1:0];
		elapsed = now_q - rd_data_q;

		tick_due  = !acked_q[i_ix] && sent_q[i_ix] && (elapsed >= {16'd0, tmo_q});
		tick_fail = tick_due && (retry_q[i_ix] >= retry_lim_q);
		tick_retx = tick_due && !tick_fail;

		ack_new = !acked_q[idx_q];
		dup_inc = (dup_q[idx_q] == 3'd7) ? 3'd7 : dup_q[idx_q] + 3'd1;
		dup3    = dup_inc == 3'd3;
		tgt_ok  = dup3 && (tgt_cw < total_q) && (tgt_cw < next_q) && !acked_q[tgt_ix];
		fr_fail = !ack_new && tgt_ok && (retry_q[tgt_ix] >= retry_lim_q);
		fr_retx = !ack_new && tgt_ok && !fr_fail;

		fl_raw = cwnd_q[11:8];
		if (fl_raw == 4'd0)
			flight = 5'd1;
		else if ({1'b0, fl_raw} > WL_C)
			flight = WL_C;
		else
			flight = {1'b0, fl_raw};
		win_end  = EW'(base_q) + EW'(flight);
		fill_go  = (next_q < total_q) && (EW'(next_q) < win_end);
		base_adv = (base_q < total_q) && acked_q[base_q[IW-1:0]];
		out_free = !res_valid_q || res.ready;

		ss_half = clamp_q({2'b00, cwnd_q[11:1]}, CWND_MAX);
		fr_cwnd = clamp_q({1'b0, ss_half} + 13'd768, CWND_MAX);

		// RTT sample, ms saturated then Q.3
		if (elapsed == 32'd0)
			el_sat = 21'd1;
		else if (elapsed > 32'd2097151)
			el_sat = 21'h1FFFFF;
		else
			el_sat = elapsed[20:0];
		s_new  = {el_sat, 3'b000};
		err    = (srtt_q > sample_q) ? srtt_q - sample_q : sample_q - srtt_q;
		rv_sum = {1'b0, rttvar_q, 1'b0} + {2'b00, rttvar_q} + {2'b00, err};
		sr_sum = {srtt_q, 3'b000} - {3'b000, srtt_q} + {3'b000, sample_q};
		tq_sum = {3'b000, srtt_q} + {1'b0, rttvar_q, 2'b00};
		tq     = tq_sum[26:3];
		if (tq < {8'd0, min_tmo_q})
			tmo_new = min_tmo_q;
		else if (tq > {8'd0, max_tmo_q})
			tmo_new = max_tmo_q;
		else
			tmo_new = tq[15:0];

		// one restoring step of 65536 / cwnd
		trial = {rem_q, div_cnt_q == 5'd0};
		ge    = trial >= {1'b0, cwnd_q};

		total_new = (32'(pkt_cnt_q) > CAP) ? CAP_C : CW'(pkt_cnt_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (entry_valid) begin
					if (entry.op == OP_START)
						state_d = ST_POST;
					else if (phase_q != PH_RUN)
						state_d = ST_STATUS;
					else if (entry.op == OP_ACK)
						state_d = (32'(entry.idx) < 32'(next_q)) ? ST_ACK_EVAL : ST_POST;
					else if (entry.op == OP_TICK)
						state_d = ST_TICK_RD;
					else
						state_d = ST_POST;
				end
			end
			ST_ACK_EVAL: begin
				if (ack_new)
					state_d = samp_q[idx_q] ? ST_RTT_UPD : ST_ACK_WIN;
				else if (fr_fail)
					state_d = ST_STATUS;
				else if (fr_retx)
					state_d = ST_FR_EMIT;
				else
					state_d = ST_BASE;
			end
			ST_RTT_UPD: state_d = ST_RTT_TMO;
			ST_RTT_TMO: state_d = ST_ACK_WIN;
			ST_ACK_WIN: begin
				if ((fr_q && idx_cw >= rp_q) || cwnd_q < ssth_q)
					state_d = ST_BASE;
				else
					state_d = ST_DIV;
			end
			ST_DIV:      if (div_cnt_q == DIV_LAST) state_d = ST_DIV_END;
			ST_DIV_END:  state_d = ST_BASE;
			ST_FR_EMIT:  if (out_free) state_d = ST_BASE;
			ST_BASE:     if (!base_adv) state_d = ST_POST;
			ST_TICK_RD:  state_d = (i_q < next_q) ? ST_TICK_EVAL : ST_POST;
			ST_TICK_EVAL: begin
				if (tick_fail)
					state_d = ST_STATUS;
				else if (tick_retx)
					state_d = ST_TICK_EMIT;
				else
					state_d = ST_TICK_RD;
			end
			ST_TICK_EMIT: if (out_free) state_d = ST_TICK_RD;
			ST_POST:      state_d = (base_q >= total_q) ? ST_STATUS : ST_FILL;
			ST_FILL:      state_d = fill_go ? ST_FILL_EMIT : ST_STATUS;
			ST_FILL_EMIT: if (out_free) state_d = ST_FILL;
			ST_STATUS:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		entry_ready = state_q == ST_IDLE;
		rd_addr     = (state_q == ST_IDLE) ? entry.idx[IW-1:0] : i_ix;
		mem_we      = 1'b0;
		mem_wa      = i_ix;
		out_load    = 1'b0;
		out_kind    = KIND_STATUS;
		out_seq     = '0;
		out_last    = 1'b0;
		unique case (state_q)
			ST_TICK_EVAL: mem_we = tick_retx;
			ST_ACK_EVAL: begin
				mem_we = fr_retx;
				mem_wa = tgt_ix;
			end
			ST_FILL: begin
				mem_we = fill_go;
				mem_wa = next_q[IW-1:0];
			end
			ST_TICK_EMIT: begin
				out_load = out_free;
				out_kind = KIND_TIMEOUT;
				out_seq  = SEQ_W'(i_q + CW'(1));
			end
			ST_FR_EMIT: begin
				out_load = out_free;
				out_kind = KIND_FAST;
				out_seq  = SEQ_W'(tgt_cw + CW'(1));
			end
			ST_FILL_EMIT: begin
				out_load = out_free;
				out_kind = KIND_SEND;
				out_seq  = SEQ_W'(next_q);
			end
			ST_STATUS: begin
				out_load = out_free;
				out_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_cnt_q   <= '0;
			init_tmo_q  <= 16'd400;
			min_tmo_q   <= 16'd120;
			max_tmo_q   <= 16'd1500;
			retry_lim_q <= 4'd15;
			init_thr_q  <= 4'd8;
			phase_q     <= PH_IDLE;
			total_q     <= '0;
			base_q      <= '0;
			next_q      <= '0;
			i_q         <= '0;
			rp_q        <= '0;
			acked_q     <= '0;
			sent_q      <= '0;
			samp_q      <= '0;
			for (int k = 0; k < CAP; k++) begin
				retry_q[k] <= '0;
				dup_q[k]   <= '0;
			end
			cwnd_q      <= ONE_Q;
			ssth_q      <= SSTH_RST;
			srtt_q      <= '0;
			rttvar_q    <= '0;
			tmo_q       <= 16'd400;
			rtt_valid_q <= 1'b0;
			fr_q        <= 1'b0;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (write_enable) begin
				unique case (write_index)
					REG_PACKET_COUNT:   pkt_cnt_q   <= write_data[4:0];
					REG_INIT_TIMEOUT:   init_tmo_q  <= write_data;
					REG_MIN_TIMEOUT:    min_tmo_q   <= write_data;
					REG_MAX_TIMEOUT:    max_tmo_q   <= write_data;
					REG_RETRY_LIMIT:    retry_lim_q <= write_data[3:0];
					REG_INIT_THRESHOLD: init_thr_q  <= write_data[3:0];
					default: ;
				endcase
			end

			if (out_load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (entry_valid && entry.op == OP_START) begin
						total_q     <= total_new;
						base_q      <= '0;
						next_q      <= '0;
						rp_q        <= '0;
						acked_q     <= '0;
						sent_q      <= '0;
						samp_q      <= '0;
						for (int k = 0; k < CAP; k++) begin
							retry_q[k] <= '0;
							dup_q[k]   <= '0;
						end
						cwnd_q      <= ONE_Q;
						ssth_q      <= clamp_q({1'b0, init_thr_q, 8'd0}, CWND_MAX);
						srtt_q      <= '0;
						rttvar_q    <= '0;
						tmo_q       <= init_tmo_q;
						rtt_valid_q <= 1'b0;
						fr_q        <= 1'b0;
						phase_q     <= PH_RUN;
					end
					i_q <= base_q;
				end
				ST_ACK_EVAL: begin
					if (ack_new) begin
						acked_q[idx_q] <= 1'b1;
						dup_q[idx_q]   <= '0;
					end else begin
						dup_q[idx_q] <= dup_inc;
						if (fr_fail) begin
							phase_q <= PH_FAIL;
						end else if (fr_retx) begin
							retry_q[tgt_ix] <= retry_q[tgt_ix] + 4'd1;
							samp_q[tgt_ix]  <= 1'b0;
							ssth_q          <= ss_half;
							cwnd_q          <= fr_cwnd;
							fr_q            <= 1'b1;
							rp_q            <= next_q - CW'(1);
						end else if (!dup3 && fr_q) begin
							cwnd_q <= clamp_q({1'b0, cwnd_q} + {1'b0, ONE_Q}, CWND_MAX);
						end
					end
				end
				ST_RTT_UPD: begin
					rtt_valid_q <= 1'b1;
					if (!rtt_valid_q) begin
						srtt_q   <= sample_q;
						rttvar_q <= {1'b0, sample_q[23:1]};
					end else begin
						srtt_q   <= sr_sum[26:3];
						rttvar_q <= rv_sum[25:2];
					end
				end
				ST_RTT_TMO: tmo_q <= tmo_new;
				ST_ACK_WIN: begin
					if (fr_q && idx_cw >= rp_q) begin
						fr_q   <= 1'b0;
						cwnd_q <= clamp_q({1'b0, ssth_q}, CWND_MAX);
					end else if (cwnd_q < ssth_q) begin
						cwnd_q <= clamp_q({1'b0, cwnd_q} + {1'b0, ONE_Q}, CWND_MAX);
					end
					div_cnt_q <= '0;
				end
				ST_DIV:     div_cnt_q <= div_cnt_q + 5'd1;
				ST_DIV_END: cwnd_q <= clamp_q({1'b0, cwnd_q} + {4'd0, quo_q}, CWND_MAX);
				ST_BASE:    if (base_adv) base_q <= base_q + CW'(1);
				ST_TICK_EVAL: begin
					if (tick_fail) begin
						phase_q <= PH_FAIL;
					end else if (tick_retx) begin
						retry_q[i_ix] <= retry_q[i_ix] + 4'd1;
						samp_q[i_ix]  <= 1'b0;
						ssth_q        <= ss_half;
						cwnd_q        <= ONE_Q;
						fr_q          <= 1'b0;
						rp_q          <= '0;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_TICK_EMIT: if (out_free) i_q <= i_q + CW'(1);
				ST_POST:      if (base_q >= total_q) phase_q <= PH_DONE;
				ST_FILL: begin
					if (fill_go) begin
						sent_q[next_q[IW-1:0]] <= 1'b1;
						samp_q[next_q[IW-1:0]] <= 1'b1;
						next_q <= next_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && entry_valid) begin
			idx_q <= entry.idx[IW-1:0];
			now_q <= entry.now;
		end
		if (state_q == ST_ACK_EVAL)
			sample_q <= s_new;
		if (state_q == ST_ACK_WIN) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? 12'(trial - {1'b0, cwnd_q}) : trial[11:0];
			quo_q <= {quo_q[7:0], ge};
		end
		if (out_load) begin
			kind_q    <= out_kind;
			seq_q     <= out_seq;
			stat_q    <= status_of(phase_q);
			win_out_q <= cwnd_q;
			thr_out_q <= ssth_q;
			tmo_out_q <= tmo_q;
			last_q    <= out_last;
		end
	end

	// send-time store
	always_ff @(posedge clk) begin
		if (mem_we)
			send_mem[mem_wa] <= now_q;
		rd_data_q <= send_mem[rd_addr];
	end

	assign res.valid           = res_valid_q;
	assign res.kind            = kind_q;
	assign res.sequence_res    = seq_q;
	assign res.transfer_status = stat_q;
	assign res.window_q        = win_out_q;
	assign res.threshold_q     = thr_out_q;
	assign res.timeout_ms      = tmo_out_q;
	assign res.last            = last_q;

	a_next_in_total: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= total_q) else $error("next unsent beyond transfer size");
	a_base_le_next: assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= next_q) else $error("window base passed next unsent");
	a_cwnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cwnd_q >= ONE_Q && cwnd_q <= CWND_MAX) else $error("cwnd out of range");
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && last_q |-> kind_q == KIND_STATUS) else $error("last on non-status");
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid && entry_ready |=> state_q != ST_IDLE) else $error("request dropped");

endmodule

FILE: rtl/selective_repeat_sender_cc.sv
// Top level of the selective-repeat sender with Reno window and RTO estimator.
//
// Each request is one event (start, acknowledgment, timer tick) with its
// millisecond stamp; it yields zero or more send/retransmit results and then
// one status result marked last. The intake decodes requests into a two-entry
// queue, so a new request is taken while the sequencer still works or a result
// waits in the output register. The sequencer handles one packet per step and
// one request at a time: a status-only event goes straight to its status result,
// a timer tick visits each outstanding packet and emits each retransmit, an
// acknowledgment updates the RTT, window and window base (the window growth
// in avoidance runs a bit-serial 17-step divide), and every new send is emitted
// before status. A stalled result output holds the sequencer.
// Send times live in a small memory with a registered read port; all other
// per-packet state is flip-flops cleared at start, so there is no clearing
// pass. Configuration writes are taken at any edge but must be done while idle.
module selective_repeat_sender_cc #(
	parameter int MAX_PACKETS_HELD = srs_pkg::MAX_PACKETS_HELD_DEF,
	parameter int WINDOW_LIMIT     = srs_pkg::WINDOW_LIMIT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	srs_req_if.sink                        req,
	srs_res_if.source                      res,
	input  logic                           write_enable,
	input  logic [srs_pkg::CFG_IDX_W-1:0]  write_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0] write_data
);
	import srs_pkg::*;

	srs_entry_t entry;      // decoded request from the intake queue
	logic       entry_valid;
	logic       entry_ready;

	srs_front #(
		.MAX_PACKETS_HELD(MAX_PACKETS_HELD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.entry      (entry),
		.entry_valid(entry_valid),
		.entry_ready(entry_ready)
	);

	srs_back #(
		.MAX_PACKETS_HELD(MAX_PACKETS_HELD),
		.WINDOW_LIMIT    (WINDOW_LIMIT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (entry),
		.entry_valid (entry_valid),
		.entry_ready (entry_ready),
		.write_enable(write_enable),
		.write_index (write_index),
		.write_data  (write_data),
		.res         (res)
	);

endmodule
